@@ rtl/core/b2a_pkg.sv @@
// Package for the binary to ASCII decimal converter: widths, stage record, digit helpers.
// Used by b2a_cell and binary_to_ascii_decimal_core. It depends on nothing.
package b2a_pkg;

   localparam int VALUE_BITS  = 16;   // binary bits converted, 4..24
   localparam int DIGIT_COUNT = 6;    // decimal digits kept, 1..8
   localparam int IN_WIDTH    = 16;   // width of the value port
   localparam int CHAR_WIDTH  = 6;    // width of one character port
   localparam int FIELD_COUNT = 6;    // character ports on the result side
   localparam int BCD_WIDTH   = 4 * DIGIT_COUNT;
   localparam int PAD_WIDTH   = 32;   // room for eight digits
   localparam int STAGE_COUNT = VALUE_BITS;

   localparam logic [3:0] ADD3_LIMIT = 4'd5;
   localparam logic [3:0] ADD3_STEP  = 4'd3;
   localparam logic [1:0] ASCII_HIGH = 2'b11;   // upper bits of '0'..'9' in six bits

   // One beat as it moves down the chain of cells.
   typedef struct packed {
      logic                  valid;
      logic [VALUE_BITS-1:0] bin;
      logic [BCD_WIDTH-1:0]  bcd;
   } stage_type;

   // ASCII code of one BCD digit, cut to six bits.
   function automatic logic [CHAR_WIDTH-1:0] to_char(input logic [3:0] digit);
      to_char = {ASCII_HIGH, digit};
   endfunction

endpackage

@@ rtl/core/binary_to_ascii_decimal_core.sv @@
// Top level of the binary to ASCII decimal converter: a chain of double dabble cells.
// Depends on b2a_pkg and b2a_cell.
//
//  channel | ports                         | handshake
//  --------+-------------------------------+------------------------------------
//  request | start, busy, req_value        | beat taken when start && !busy
//  result  | rsp_valid, rsp_char_*         | one-cycle strobe, cannot be held off
//
// One beat enters every cycle; busy stays low.
// One cell per binary bit, each cell a register stage.
// Synchronous reset drops every beat in flight; nothing else needs clearing.
// The result side has no stall, so the chain advances every cycle.
module binary_to_ascii_decimal_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [b2a_pkg::IN_WIDTH-1:0]        req_value,
   output logic                                rsp_valid,
   output logic [b2a_pkg::CHAR_WIDTH-1:0]      rsp_char_units,
   output logic [b2a_pkg::CHAR_WIDTH-1:0]      rsp_char_tens,
   output logic [b2a_pkg::CHAR_WIDTH-1:0]      rsp_char_hundreds,
   output logic [b2a_pkg::CHAR_WIDTH-1:0]      rsp_char_thousands,
   output logic [b2a_pkg::CHAR_WIDTH-1:0]      rsp_char_ten_thousands,
   output logic [b2a_pkg::CHAR_WIDTH-1:0]      rsp_char_hundred_thousands
);

   b2a_pkg::stage_type              chain [b2a_pkg::STAGE_COUNT+1];
   logic [b2a_pkg::PAD_WIDTH-1:0]   value_ext;
   logic [b2a_pkg::PAD_WIDTH-1:0]   bcd_pad;

   assign busy = 1'b0;

   // Keep only the low VALUE_BITS bits of the request.
   assign value_ext       = b2a_pkg::PAD_WIDTH'(req_value);
   assign chain[0].valid  = start;
   assign chain[0].bin    = value_ext[b2a_pkg::VALUE_BITS-1:0];
   assign chain[0].bcd    = '0;

   for (genvar s = 0; s < b2a_pkg::STAGE_COUNT; s++) begin : g_cell
      b2a_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_in  (chain[s]),
         .stage_out (chain[s+1])
      );
   end

   // Digits beyond DIGIT_COUNT read as zero and come out as '0'.
   assign bcd_pad = b2a_pkg::PAD_WIDTH'(chain[b2a_pkg::STAGE_COUNT].bcd);

   assign rsp_valid                  = chain[b2a_pkg::STAGE_COUNT].valid;
   assign rsp_char_units             = b2a_pkg::to_char(bcd_pad[3:0]);
   assign rsp_char_tens              = b2a_pkg::to_char(bcd_pad[7:4]);
   assign rsp_char_hundreds          = b2a_pkg::to_char(bcd_pad[11:8]);
   assign rsp_char_thousands         = b2a_pkg::to_char(bcd_pad[15:12]);
   assign rsp_char_ten_thousands     = b2a_pkg::to_char(bcd_pad[19:16]);
   assign rsp_char_hundred_thousands = b2a_pkg::to_char(bcd_pad[23:20]);

`ifndef ASSERT_OFF
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##(b2a_pkg::STAGE_COUNT) rsp_valid)
      else $error("accepted beat did not reach the result side on time");

   a_no_ghost: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, b2a_pkg::STAGE_COUNT))
      else $error("result strobe without a matching request beat");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_char_units[3:0] <= 4'd9) && (rsp_char_tens[3:0] <= 4'd9)
                 && (rsp_char_hundreds[3:0] <= 4'd9) && (rsp_char_thousands[3:0] <= 4'd9)
                 && (rsp_char_ten_thousands[3:0] <= 4'd9)
                 && (rsp_char_hundred_thousands[3:0] <= 4'd9))
      else $error("result digit is not decimal");

   a_zero_value: assert property (@(posedge clock) disable iff (reset)
      (start && (value_ext[b2a_pkg::VALUE_BITS-1:0] == '0))
         |-> ##(b2a_pkg::STAGE_COUNT) (bcd_pad == '0))
      else $error("zero input did not convert to all zero digits");
`endif

endmodule

@@ rtl/core/b2a_cell.sv @@
// One cell of the double dabble chain: add 3 to every BCD digit of 5 or more,
// then shift in the next binary bit. Depends on b2a_pkg.
module b2a_cell (
   input  logic                clock,
   input  logic                reset,
   input  b2a_pkg::stage_type  stage_in,
   output b2a_pkg::stage_type  stage_out
);

   b2a_pkg::stage_type             stage_ff;
   b2a_pkg::stage_type             stage_in_next;
   logic [b2a_pkg::BCD_WIDTH-1:0]  adj_bcd;

   always_comb begin
      adj_bcd = stage_in.bcd;
      for (int k = 0; k < b2a_pkg::DIGIT_COUNT; k++) begin
         if (stage_in.bcd[4*k +: 4] >= b2a_pkg::ADD3_LIMIT) begin
            adj_bcd[4*k +: 4] = stage_in.bcd[4*k +: 4] + b2a_pkg::ADD3_STEP;
         end
      end
   end

   // Digits above the kept ones never feed back down, so drop the carry out of the top.
   always_comb begin
      stage_in_next.valid = stage_in.valid;
      stage_in_next.bin   = {stage_in.bin[b2a_pkg::VALUE_BITS-2:0], 1'b0};
      stage_in_next.bcd   = {adj_bcd[b2a_pkg::BCD_WIDTH-2:0],
                             stage_in.bin[b2a_pkg::VALUE_BITS-1]};
   end

   always_ff @(posedge clock) begin
      stage_ff.bin <= stage_in_next.bin;
      stage_ff.bcd <= stage_in_next.bcd;
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in_next.valid;
      end
   end

   assign stage_out = stage_ff;

endmodule
